/* rtl/core/matrix_vector_multiply_accumulate_macros.svh */
// Assertion helpers for the matrix-vector block.
`ifndef MATRIX_VECTOR_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_ACCUMULATE_MACROS_SVH

// Same-cycle implication.
`define MVMA_ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MVMA_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mvma_pkg.sv */
package mvma_pkg;

  // operation codes carried on the input tuser
  localparam logic [1:0] OP_VEC_WRITE = 2'd0;
  localparam logic [1:0] OP_OLD_Y     = 2'd1;
  localparam logic [1:0] OP_MATRIX    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_BETA     = 2'd1;
  localparam logic [1:0] REG_COLUMNS  = 2'd2;
  localparam logic [1:0] REG_ROWS     = 2'd3;

  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS    = 65536;

  localparam logic signed [15:0] ALPHA_RESET   = 16'sd256;
  localparam logic signed [15:0] BETA_RESET    = 16'sd0;
  localparam logic [8:0]         COLUMNS_RESET = 9'd256;
  localparam logic [15:0]        ROWS_RESET    = 16'd1;

  // row bookkeeping that travels with a matrix element down the pipe
  typedef struct packed {
    logic [15:0] row_number;
    logic        last_row;
    logic        last_col;
  } mvma_row_tag_t;

endpackage

/* rtl/core/matrix_vector_multiply_accumulate.sv */
// Streaming y = alpha*A*x + beta*y in signed Q8.8.
// Input stream (s_*): tuser holds the op, tdata the index and value.
//   op 0 loads x[index], op 1 gives the old y of the current row,
//   op 2 carries the next matrix element in row-major order.
// Output stream (m_*): one beat per finished row; tdata holds the result
//   and the row number, tlast marks the final row, tuser the clip flag.
// Config port: cfg_write/cfg_index/cfg_data, written while the block is idle.
// Rate: one input beat per cycle, every op, unless stalled. The x store
//   is a single synchronous RAM read once per matrix element; the
//   multiply-accumulate and alpha/beta scaling are pipelined; nothing iterates.
// Path: a row's last matrix element passes the element and x register, the
//   product, the closing sum, the scaling, the total and the output register.
// Reset: column and row positions, accumulator and old y clear, registers
//   take their defaults; the x store keeps whatever it held and must be
//   loaded before use. No clearing pass is needed.
// Stall: each pipeline stage holds when the next one is full, so the block
//   keeps taking beats while a result waits, until the pipe fills up; then
//   s_tready drops. Ops 0 and 1 never enter the pipe.
`include "matrix_vector_multiply_accumulate_macros.svh"

module matrix_vector_multiply_accumulate
  import mvma_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] element_index, [23:8] element_value
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] result_value, [31:16] row_number
  output logic        m_tlast,   // last_row
  output logic [0:0]  m_tuser,   // [0] saturated
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int NCW = ($clog2(MAX_COLUMNS + 1) > 9) ? $clog2(MAX_COLUMNS + 1) : 9;
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int NRW = ($clog2(MAX_ROWS + 1) > 16) ? $clog2(MAX_ROWS + 1) : 16;
  localparam int RNW = (RW > 16) ? RW : 16;

  // configuration
  logic signed [15:0] alpha_scale;
  logic signed [15:0] beta_scale;
  logic [8:0]         column_count;
  logic [15:0]        row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_scale  <= ALPHA_RESET;
      beta_scale   <= BETA_RESET;
      column_count <= COLUMNS_RESET;
      row_count    <= ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALPHA:   alpha_scale  <= cfg_data;
        REG_BETA:    beta_scale   <= cfg_data;
        REG_COLUMNS: column_count <= cfg_data[8:0];
        REG_ROWS:    row_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective counts, clamped to 1..MAX
  logic [NCW-1:0] ncols;
  logic [NRW-1:0] nrows;

  always_comb begin
    if (column_count == 9'd0) begin
      ncols = NCW'(1);
    end else if (NCW'(column_count) > NCW'(MAX_COLUMNS)) begin
      ncols = NCW'(MAX_COLUMNS);
    end else begin
      ncols = NCW'(column_count);
    end
    if (row_count == 16'd0) begin
      nrows = NRW'(1);
    end else if (NRW'(row_count) > NRW'(MAX_ROWS)) begin
      nrows = NRW'(MAX_ROWS);
    end else begin
      nrows = NRW'(row_count);
    end
  end

  // input fields
  logic [1:0]         in_op;
  logic [7:0]         in_index;
  logic signed [15:0] in_value;

  assign in_op    = s_tuser;
  assign in_index = s_tdata[7:0];
  assign in_value = s_tdata[23:8];

  // pipeline handshake: a stage takes a beat when empty or when it moves on
  logic v1, v2, v3, v4, v5;
  logic move1, move2, move3, move4, move5;
  logic can1, can2, can3, can4, can5, can_out;
  mvma_row_tag_t tag1, tag2, tag3, tag4, tag5;

  assign can_out = !m_tvalid || m_tready;
  assign move5   = v5 && can_out;
  assign can5    = !v5 || can_out;
  assign move4   = v4 && can5;
  assign can4    = !v4 || can5;
  assign move3   = v3 && can4;
  assign can3    = !v3 || can4;
  // only a row-closing element goes past the accumulator
  assign move2   = v2 && (!tag2.last_col || can3);
  assign can2    = !v2 || move2;
  assign move1   = v1 && can2;
  assign can1    = !v1 || can2;

  assign s_tready = can1;

  logic s_accept;
  logic load1;
  assign s_accept = s_tvalid && s_tready;
  assign load1    = s_accept && (in_op == OP_MATRIX);

  // row / column tracking at the input side
  logic [CW-1:0]      col_pos;
  logic [RW-1:0]      row_pos;
  logic signed [15:0] old_y;
  logic [NCW-1:0]     col_inc;
  logic [NRW-1:0]     row_inc;
  logic [RNW-1:0]     row_wide;
  logic               last_col;
  logic               last_row;

  assign col_inc  = NCW'(col_pos) + NCW'(1);
  assign row_inc  = NRW'(row_pos) + NRW'(1);
  assign last_col = col_inc >= ncols;
  assign last_row = row_inc >= nrows;
  assign row_wide = RNW'(row_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      old_y   <= '0;
    end else if (s_accept) begin
      case (in_op)
        OP_OLD_Y: old_y <= in_value;
        OP_MATRIX: begin
          if (last_col) begin
            col_pos <= '0;
            old_y   <= '0;
            row_pos <= last_row ? '0 : row_inc[RW-1:0];
          end else begin
            col_pos <= col_inc[CW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // x store
  localparam int AW = ($clog2(MAX_COLUMNS + 1) > 8) ? $clog2(MAX_COLUMNS + 1) : 8;

  logic [15:0]        vec_mem [MAX_COLUMNS];
  logic [AW-1:0]      wr_index;
  logic               vec_we;
  logic signed [15:0] x1;

  assign wr_index = AW'(in_index);
  assign vec_we   = s_accept && (in_op == OP_VEC_WRITE) && (wr_index < AW'(MAX_COLUMNS));

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[wr_index[CW-1:0]] <= in_value;
    end
    if (load1) begin
      x1 <= vec_mem[col_pos];
    end
  end

  // stage 1: element and x word; stage 2: product
  logic signed [15:0] val1, oldy1, oldy2, oldy3;
  logic signed [31:0] prod2;

  always_ff @(posedge clk) begin
    if (load1) begin
      val1                <= in_value;
      oldy1               <= old_y;
      tag1.row_number     <= row_wide[15:0];
      tag1.last_row       <= last_row;
      tag1.last_col       <= last_col;
    end
    if (move1) begin
      prod2 <= val1 * x1;
      oldy2 <= oldy1;
      tag2  <= tag1;
    end
  end

  // accumulator; the row-closing sum goes on to stage 3
  logic signed [47:0] acc;
  logic signed [47:0] acc_sum;
  logic signed [47:0] accf3;

  assign acc_sum = acc + 48'(prod2);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (move2) begin
      acc <= tag2.last_col ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (move2 && tag2.last_col) begin
      accf3 <= acc_sum;
      oldy3 <= oldy2;
      tag3  <= tag2;
    end
  end

  // stage 4: alpha*acc split in two halves, beta*old y
  logic signed [40:0] plo4;
  logic signed [39:0] phi4;
  logic signed [31:0] bo4;
  logic signed [63:0] total5;

  always_ff @(posedge clk) begin
    if (move3) begin
      plo4 <= alpha_scale * $signed({1'b0, accf3[23:0]});
      phi4 <= alpha_scale * $signed(accf3[47:24]);
      bo4  <= beta_scale * oldy3;
      tag4 <= tag3;
    end
    if (move4) begin
      total5 <= (64'(phi4) <<< 24) + 64'(plo4) + (64'(bo4) <<< 8);
      tag5   <= tag4;
    end
  end

  // output: round half up, floor shift, saturate
  logic signed [63:0] rounded;
  logic signed [63:0] q;
  logic signed [15:0] q_sat;
  logic               sat;

  assign rounded = total5 + 64'sd32768;
  assign q       = rounded >>> 16;

  always_comb begin
    if (q > 64'sd32767) begin
      q_sat = 16'sh7FFF;
      sat   = 1'b1;
    end else if (q < -64'sd32768) begin
      q_sat = 16'sh8000;
      sat   = 1'b1;
    end else begin
      q_sat = q[15:0];
      sat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move5) begin
      m_tdata    <= {tag5.row_number, q_sat};
      m_tlast    <= tag5.last_row;
      m_tuser[0] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v1       <= load1 || (v1 && !move1);
      v2       <= move1 || (v2 && !move2);
      v3       <= (move2 && tag2.last_col) || (v3 && !move3);
      v4       <= move3 || (v4 && !move4);
      v5       <= move4 || (v5 && !move5);
      m_tvalid <= move5 || (m_tvalid && !m_tready);
    end
  end

  `MVMA_ASSERT_NEXT(a_close_reaches_stage3, clk, rst, move2 && tag2.last_col, v3,
                    "row-closing sum lost before scaling")
  `MVMA_ASSERT_NEXT(a_acc_cleared, clk, rst, move2 && tag2.last_col, acc == 48'sd0,
                    "accumulator not cleared after a row")
  `MVMA_ASSERT_NEXT(a_col_wraps, clk, rst, load1 && last_col, col_pos == '0,
                    "column position did not wrap at row end")
  `MVMA_ASSERT_IMPL(a_out_from_stage5, clk, rst, $rose(m_tvalid), $past(v5),
                    "result appeared without a scaled sum")

endmodule

/* tb/tb_matrix_vector_multiply_accumulate.sv */
`timescale 1ns / 100ps

module tb_matrix_vector_multiply_accumulate;
  import mvma_pkg::*;

  // op code the block has no use for; it must pass without effect
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one finished row as it should leave the block
  typedef struct {
    logic [15:0] value;
    logic [15:0] row;
    logic        last;
    logic        sat;
  } row_result_t;

  // Row predictor and result scoreboard: keeps its own copy of the x store,
  // the accumulator, the positions and the registers, and queues the row
  // results that accepted beats must produce.
  class gemv_scoreboard;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [8:0]         cols_reg;
    logic [15:0]        rows_reg;
    logic signed [15:0] x_store[256];
    bit                 x_written[256];
    logic signed [47:0] acc;
    logic signed [15:0] old_y;
    int unsigned        col_pos;
    int unsigned        row_pos;
    row_result_t        expected_rows[$];
    int                 errors;

    function void reset_state();
      alpha    = ALPHA_RESET;
      beta     = BETA_RESET;
      cols_reg = COLUMNS_RESET;
      rows_reg = ROWS_RESET;
      foreach (x_written[i]) x_written[i] = 1'b0;
      acc     = '0;
      old_y   = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_ALPHA:   alpha    = data;
        REG_BETA:    beta     = data;
        REG_COLUMNS: cols_reg = data[8:0];
        REG_ROWS:    rows_reg = data;
        default: ;
      endcase
    endfunction

    function void note_beat(logic [1:0] op, logic [7:0] idx, logic signed [15:0] val);
      int unsigned        ncols;
      int unsigned        nrows;
      logic signed [31:0] prod;
      longint             total;
      longint             q;
      row_result_t        res;
      case (op)
        OP_VEC_WRITE: begin
          x_store[idx]   = val;
          x_written[idx] = 1'b1;
        end
        OP_OLD_Y: old_y = val;
        OP_MATRIX: begin
          // zero counts act as one, oversized column counts as the store size
          ncols = (cols_reg == 0) ? 1 : ((cols_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols_reg);
          nrows = (rows_reg == 0) ? 1 : rows_reg;
          prod  = val * x_store[col_pos];
          acc   = acc + prod;
          if (col_pos + 1 < ncols) begin
            col_pos++;
          end else begin
            // Q40.24 sum, round half up, then clip to Q8.8
            total = longint'(alpha) * longint'(acc) + longint'(beta) * longint'(old_y) * 256;
            q = (total + 64'sd32768) >>> 16;
            res.sat = 1'b0;
            if (q > 32767) begin
              q = 32767;
              res.sat = 1'b1;
            end
            if (q < -32768) begin
              q = -32768;
              res.sat = 1'b1;
            end
            res.value = q[15:0];
            res.row   = row_pos[15:0];
            res.last  = (row_pos + 1 >= nrows);
            expected_rows.push_back(res);
            row_pos = res.last ? 0 : row_pos + 1;
            col_pos = 0;
            acc     = '0;
            old_y   = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("%0t: row mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_row(logic [31:0] tdata, logic tlast, logic [0:0] tuser);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, data %h", tdata));
        return;
      end
      want = expected_rows.pop_front();
      if (tdata[15:0] !== want.value)
        report_mismatch($sformatf("row %0d value %h, want %h", want.row, tdata[15:0], want.value));
      if (tdata[31:16] !== want.row)
        report_mismatch($sformatf("row number %0d, want %0d", tdata[31:16], want.row));
      if (tlast !== want.last)
        report_mismatch($sformatf("row %0d last flag %b, want %b", want.row, tlast, want.last));
      if (tuser[0] !== want.sat)
        report_mismatch($sformatf("row %0d clip flag %b, want %b", want.row, tuser[0], want.sat));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [7:0] element_index, [23:8] element_value
  logic [1:0]  s_tuser = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [31:0] m_tdata;        // [15:0] result_value, [31:16] row_number
  logic        m_tlast;
  logic [0:0]  m_tuser;        // [0] saturated
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_ALPHA;
  logic [15:0] cfg_data = '0;

  gemv_scoreboard sb = new();

  int unsigned random_beats = 0;
  int          stall_left = 0;
  bit          rx_burst = 1'b0;

  matrix_vector_multiply_accumulate dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Result side: check each accepted beat, then hold tready low for a drawn
  // number of cycles. Now and then flip into a run with no stalls at all.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_row(m_tdata, m_tlast, m_tuser);
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      stall_left = rx_burst ? 0 : $urandom_range(0, 9);
      m_tready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= (stall_left == 0);
    end
  end

  // Entered and left at a rising edge. tvalid stays high across back-to-back
  // beats; this task only drops it when a gap is drawn.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] idx,
                           input logic [15:0] val, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {val, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_beat(op, idx, val);
  endtask

  // Register writes, one per cycle; the predictor follows at each write edge.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input bit [3:0] mask, input logic [15:0] a_val,
                           input logic [15:0] b_val, input logic [15:0] c_val,
                           input logic [15:0] r_val);
    if (mask[REG_ALPHA])   write_reg(REG_ALPHA, a_val);
    if (mask[REG_BETA])    write_reg(REG_BETA, b_val);
    if (mask[REG_COLUMNS]) write_reg(REG_COLUMNS, c_val);
    if (mask[REG_ROWS])    write_reg(REG_ROWS, r_val);
    cfg_write <= 1'b0;
  endtask

  // Sender holds off until every row result is back, then lets the pipe
  // run dry before anything touches the registers.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value(bit small_mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h7FFF;
    if (r < 16) return 16'h8000;
    if (small_mode || r < 40) return 16'($urandom_range(0, 600) - 300);
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0100;
      3: return 16'hFF00;
      4: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly whole rows of matrix beats with an old y at the row start; x
  // rewrites, stray old y beats and unused ops break the rows up. An x entry
  // is always loaded before a matrix beat can read it.
  task automatic run_phase(input int budget, input bit burst, input bit small_mode);
    int         sent;
    int         r;
    logic [1:0] op;
    logic [7:0] idx;
    logic [15:0] val;
    sent = 0;
    while (sent < budget) begin
      r   = $urandom_range(0, 99);
      idx = 8'($urandom_range(0, 255));
      val = pick_value(small_mode);
      if (r < 3) begin
        op = OP_UNUSED;
      end else if (r < 9) begin
        op = OP_VEC_WRITE;
      end else if (r < 14) begin
        op = OP_OLD_Y;
      end else if (r < 17 || !sb.x_written[sb.col_pos]) begin
        op  = OP_VEC_WRITE;
        idx = 8'(sb.col_pos);
      end else if (sb.col_pos == 0 && r < 40) begin
        op = OP_OLD_Y;
      end else begin
        op = OP_MATRIX;
      end
      send_beat(op, idx, val, burst ? 0 : $urandom_range(0, 9));
      if (op != OP_UNUSED) sent++;
    end
    random_beats += sent;
  endtask

  initial begin
    int          phase;
    int          large_left;
    int          budget;
    bit [3:0]    mask;
    logic [15:0] a_val, b_val, c_val, r_val;

    sb.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: two columns, three rows, beta at 1.0
    configure(4'b1111, 16'h0100, 16'h0100, 16'd2, 16'd3);
    send_beat(OP_VEC_WRITE, 8'd0, 16'h7FFF, 0);
    send_beat(OP_VEC_WRITE, 8'd1, 16'h8000, 0);
    send_beat(OP_VEC_WRITE, 8'hFF, 16'hFFFF, 1);
    send_beat(OP_OLD_Y, 8'd0, 16'h7FFF, 0);
    // second old y in the same row replaces the first
    send_beat(OP_OLD_Y, 8'hFF, 16'h8000, 0);
    // row 0: both products at full positive scale, clips high
    send_beat(OP_MATRIX, 8'd0, 16'h7FFF, 0);
    send_beat(OP_MATRIX, 8'd0, 16'h8000, 2);
    send_beat(OP_UNUSED, 8'hFF, 16'hFFFF, 0);
    // row 1: opposite signs, clips low
    send_beat(OP_MATRIX, 8'd0, 16'h8000, 0);
    send_beat(OP_MATRIX, 8'hFF, 16'h7FFF, 0);
    // row 2: small element values, last row, position wraps
    send_beat(OP_MATRIX, 8'd0, 16'hFF00, 0);
    send_beat(OP_MATRIX, 8'd0, 16'h0001, 3);
    send_beat(OP_VEC_WRITE, 8'hAA, 16'h5555, 0);
    send_beat(OP_MATRIX, 8'd0, 16'h8000, 0);
    send_beat(OP_MATRIX, 8'd0, 16'h8000, 0);
    wait_idle();

    // Random phases; the first three pin the register extremes. A phase may
    // stop mid-row, so the next setting can shrink the row under way.
    phase      = 0;
    large_left = 2;
    while (random_beats < 1650) begin
      phase++;
      a_val = pick_scale();
      b_val = pick_scale();
      case (phase)
        1: begin
          mask  = 4'b1111;
          a_val = 16'h8000;
          b_val = 16'h7FFF;
          c_val = 16'd1;
          r_val = 16'hFFFF;
        end
        2: begin
          mask  = 4'b1111;
          a_val = 16'h7FFF;
          b_val = 16'h8000;
          c_val = 16'h01FF;
          r_val = 16'd0;
          large_left--;
        end
        3: begin
          mask  = 4'b1110;
          b_val = 16'h0000;
          c_val = 16'd0;
          r_val = 16'd2;
        end
        default: begin
          mask = 4'($urandom_range(0, 15));
          mask[REG_COLUMNS] = 1'b1;
          case ($urandom_range(0, 9))
            0: c_val = 16'd0;
            1: c_val = 16'd1;
            2: begin
              if (large_left > 0) begin
                c_val = 16'd256;
                large_left--;
              end else begin
                c_val = 16'd3;
              end
            end
            default: c_val = 16'($urandom_range(2, 8));
          endcase
          case ($urandom_range(0, 4))
            0: r_val = 16'd0;
            1: r_val = 16'd1;
            2: r_val = 16'hFFFF;
            default: r_val = 16'($urandom_range(2, 5));
          endcase
        end
      endcase
      configure(mask, a_val, b_val, c_val, r_val);
      budget = (sb.cols_reg > 16) ? 300 : $urandom_range(40, 110);
      // last phase only tops the count up
      if (budget > 1650 - int'(random_beats)) budget = 1650 - int'(random_beats);
      run_phase(budget, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
